FILE: sv/servo_gait_sequencer_defines.svh
// Assertion macros shared by the servo gait sequencer RTL.
`ifndef SERVO_GAIT_SEQUENCER_DEFINES_SVH
`define SERVO_GAIT_SEQUENCER_DEFINES_SVH
// Asserts that an implication holds on every clock edge outside reset.
`define SGS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that the consequence holds in the cycle after the antecedent.
`define SGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: sv/sgs_pkg.sv
// Package with the state codes, tables and pulse conversion of the gait sequencer.
package sgs_pkg;
  localparam int unsigned SERVO_COUNT = 8;
  localparam int unsigned PHASE_COUNT = 4;
  localparam logic [17:0] HOLD_TIMEOUT_MS = 18'd180000;
  localparam logic [17:0] ELAPSED_LIMIT = 18'd262143;
  localparam logic [4:0] POSE_CODE = 5'd31;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_WALK = 3'd1;
  localparam logic [2:0] OP_POSE = 3'd2;
  localparam logic [2:0] OP_LEG  = 3'd3;
  localparam logic [2:0] OP_INIT = 3'd4;

  localparam logic [2:0] M_OFF     = 3'd0;
  localparam logic [2:0] M_NEUTRAL = 3'd1;
  localparam logic [2:0] M_NORMAL  = 3'd2;
  localparam logic [2:0] M_REP0    = 3'd3;
  localparam logic [2:0] M_POSE    = 3'd7;

  localparam logic [2:0] ADDR_STEP_DELAY = 3'd0;

  typedef logic [2:0] cls_t;
  typedef cls_t [SERVO_COUNT-1:0] cls_vec_t;

  function automatic logic [2:0] chan_of(input logic [2:0] slot);
    logic [2:0] r;
    case (slot)
      3'd0: r = 3'd1;
      3'd1: r = 3'd0;
      3'd2: r = 3'd5;
      3'd3: r = 3'd4;
      3'd4: r = 3'd3;
      3'd5: r = 3'd2;
      3'd6: r = 3'd7;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] angle_of(input cls_t c, input logic [2:0] s);
    logic [7:0] r;
    r = 8'd0;
    case (c)
      3'd1: case (s)
        3'd0: r = 8'd70; 3'd1: r = 8'd85; 3'd2: r = 8'd68;
        default: r = 8'd90;
      endcase
      3'd2: case (s)
        3'd0: r = 8'd58; 3'd1: r = 8'd60; 3'd2: r = 8'd55; 3'd3: r = 8'd80;
        3'd4: r = 8'd105; 3'd5: r = 8'd110; 3'd6: r = 8'd103; default: r = 8'd90;
      endcase
      3'd3: case (s)
        3'd0: r = 8'd80; 3'd1: r = 8'd90; 3'd2: r = 8'd75; 3'd3: r = 8'd110;
        3'd7: r = 8'd60; default: r = 8'd80;
      endcase
      3'd4: case (s)
        3'd0: r = 8'd130; 3'd1: r = 8'd85; 3'd2: r = 8'd130; 3'd4: r = 8'd20;
        3'd6: r = 8'd20; default: r = 8'd90;
      endcase
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Pulse for the table angles, 20 degrees up, else 0; a small table avoids a divider.
  function automatic logic [8:0] pulse_of(input logic [7:0] deg);
    logic [8:0] r;
    case (deg)
      8'd20:  r = 9'd200;
      8'd55:  r = 9'd263;
      8'd58:  r = 9'd269;
      8'd60:  r = 9'd272;
      8'd68:  r = 9'd287;
      8'd70:  r = 9'd290;
      8'd75:  r = 9'd300;
      8'd80:  r = 9'd309;
      8'd85:  r = 9'd318;
      8'd90:  r = 9'd327;
      8'd103: r = 9'd350;
      8'd105: r = 9'd354;
      8'd110: r = 9'd363;
      8'd130: r = 9'd400;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic cls_vec_t mk(input int a0, a1, a2, a3, a4, a5, a6, a7);
    cls_vec_t v;
    v[0] = 3'(a0); v[1] = 3'(a1); v[2] = 3'(a2); v[3] = 3'(a3);
    v[4] = 3'(a4); v[5] = 3'(a5); v[6] = 3'(a6); v[7] = 3'(a7);
    return v;
  endfunction

  function automatic cls_vec_t gait_tab(input logic [3:0] pat, input logic [1:0] ph);
    cls_vec_t v;
    v = mk(0,0,0,0,0,0,0,0);
    case (pat)
      4'd1: case (ph) 2'd0: v = mk(0,3,0,2,0,2,0,3); 2'd1: v = mk(3,0,2,0,2,0,3,0);
        2'd2: v = mk(0,2,0,3,0,3,0,2); default: v = mk(2,0,3,0,3,0,2,0); endcase
      4'd2: case (ph) 2'd0: v = mk(0,3,0,2,0,2,0,3); 2'd1: v = mk(2,0,3,0,3,0,2,0);
        2'd2: v = mk(0,2,0,3,0,3,0,2); default: v = mk(3,0,2,0,2,0,3,0); endcase
      4'd3: case (ph) 2'd0: v = mk(0,3,0,2,0,3,0,2); 2'd1: v = mk(2,0,3,0,3,0,2,0);
        2'd2: v = mk(0,2,0,3,0,2,0,3); default: v = mk(3,0,2,0,2,0,3,0); endcase
      4'd4: case (ph) 2'd0: v = mk(0,3,0,2,0,3,0,2); 2'd1: v = mk(3,0,2,0,2,0,3,0);
        2'd2: v = mk(0,2,0,3,0,2,0,3); default: v = mk(2,0,3,0,3,0,2,0); endcase
      4'd5: case (ph) 2'd0: v = mk(0,3,0,3,0,3,0,3); 2'd1: v = mk(2,0,3,0,3,0,2,0);
        2'd2: v = mk(0,2,0,2,0,2,0,2); default: v = mk(3,0,2,0,2,0,3,0); endcase
      4'd6: case (ph) 2'd0: v = mk(0,3,0,3,0,3,0,3); 2'd1: v = mk(3,0,2,0,2,0,3,0);
        2'd2: v = mk(0,2,0,2,0,2,0,2); default: v = mk(2,0,3,0,3,0,2,0); endcase
      4'd7:  if (ph == 2'd0) v = mk(2,0,2,0,2,0,2,0);
      4'd8:  if (ph == 2'd0) v = mk(4,0,4,0,4,0,4,0);
      4'd9:  if (ph == 2'd0) v = mk(2,0,4,0,2,0,4,0);
      4'd10: if (ph == 2'd0) v = mk(4,0,2,0,4,0,2,0);
      4'd11: if (ph == 2'd0) v = mk(2,0,2,0,4,0,4,0);
      4'd12: if (ph == 2'd0) v = mk(4,0,4,0,2,0,2,0);
      4'd13: v = ph[0] ? mk(2,0,4,0,2,0,4,0) : mk(2,0,2,0,2,0,2,0);
      4'd14: v = ph[0] ? mk(2,0,2,0,4,0,4,0) : mk(4,0,4,0,2,0,2,0);
      4'd15: v = ph[0] ? mk(4,0,4,0,4,0,4,0) : mk(2,0,2,0,2,0,2,0);
      default: v = mk(0,0,0,0,0,0,0,0);
    endcase
    return v;
  endfunction
endpackage

FILE: sv/servo_gait_sequencer.sv
// Top level of the servo gait sequencer: decode, state and a per-slot write sequencer.
// An item is accepted in S_IDLE and decided in S_DEC, the cycle after; then the eight servo
// slots are walked one per cycle unless out_stall holds the output, each write leaving
// through a single output register, and a closing step emits the no-write result when
// the item wrote nothing. The input is ready only in S_IDLE, which out_stall can delay.
// Pulse widths come from a constant table over the angles in use.
`include "servo_gait_sequencer_defines.svh"
module servo_gait_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [4:0] in_command,
  input  logic [2:0] in_leg_index,
  input  logic [2:0] in_level_0,
  input  logic [2:0] in_level_1,
  input  logic [2:0] in_level_2,
  input  logic [2:0] in_level_3,
  input  logic [2:0] in_level_4,
  input  logic [2:0] in_level_5,
  input  logic [2:0] in_level_6,
  input  logic [2:0] in_level_7,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_write_valid,
  output logic [2:0] out_channel,
  output logic [8:0] out_pulse,
  output logic       out_led_on,
  output logic       out_servo_on,
  output logic       out_last,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  import sgs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DEC = 4'b0010, S_RUN = 4'b0100, S_FIN = 4'b1000
  } state_t;

  state_t     state_r;
  logic [15:0] step_delay_r;
  logic [2:0] mode_r;
  logic [3:0] pattern_r;
  logic [17:0] elapsed_r;
  logic [4:0] last_cmd_r;
  logic       blink_r;

  logic [2:0] op_r;
  logic [4:0] com_r;
  logic [2:0] leg_r;
  cls_vec_t   lvl_r;
  cls_vec_t   cls_r;
  logic       alloff_r;
  logic [2:0] slot_r;
  logic       any_r;

  logic       ov_r, owv_r, olast_r, oled_r, oson_r;
  logic [2:0] och_r;
  logic [8:0] opl_r;

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ADDR_STEP_DELAY[0]) ? {16'd0, step_delay_r} : 32'd0;

  assign out_valid = ov_r;
  assign out_write_valid = owv_r;
  assign out_channel = och_r;
  assign out_pulse = opl_r;
  assign out_led_on = oled_r;
  assign out_servo_on = oson_r;
  assign out_last = olast_r;

  cls_t       cur_cls;
  logic [7:0] cur_deg;
  logic [8:0] cur_pulse;
  logic       cur_wr;
  assign cur_cls = cls_r[slot_r];
  assign cur_deg = angle_of(cur_cls, slot_r);
  assign cur_pulse = pulse_of(cur_deg);
  assign cur_wr = alloff_r || (cur_cls != 3'd0 && cur_deg >= 8'd20);

  logic more_wr;
  always_comb begin
    more_wr = 1'b0;
    for (int j = 0; j < SERVO_COUNT; j++)
      if (3'(j) > slot_r && (alloff_r || cls_r[j] != 3'd0)) more_wr = 1'b1;
  end

  logic emit_wr, emit_none;
  assign emit_wr = (state_r == S_RUN) && out_free && cur_wr;
  assign emit_none = (state_r == S_FIN) && out_free && !any_r;

  logic [17:0] el_inc;
  logic [1:0]  nph;
  assign el_inc = (elapsed_r < ELAPSED_LIMIT) ? elapsed_r + 18'd1 : elapsed_r;
  assign nph = 2'(mode_r - M_REP0 + 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; step_delay_r <= 16'd200; mode_r <= M_OFF; pattern_r <= 4'd0;
      elapsed_r <= 18'd0; last_cmd_r <= 5'd0; blink_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == ADDR_STEP_DELAY[0])
        step_delay_r <= cfg_pwdata[15:0];
      ov_r <= emit_wr || emit_none || (ov_r && out_stall);
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_opcode; com_r <= in_command; leg_r <= in_leg_index;
          lvl_r <= {in_level_7, in_level_6, in_level_5, in_level_4,
                    in_level_3, in_level_2, in_level_1, in_level_0};
          state_r <= S_DEC;
        end
        S_DEC: begin
          state_r <= S_RUN; slot_r <= 3'd0; any_r <= 1'b0; alloff_r <= 1'b0;
          cls_r <= mk(0,0,0,0,0,0,0,0);
          case (op_r)
            OP_TICK: begin
              elapsed_r <= el_inc;
              if (mode_r == M_POSE || mode_r == M_NORMAL) begin
                if (el_inc >= HOLD_TIMEOUT_MS) begin
                  alloff_r <= 1'b1; blink_r <= 1'b0; mode_r <= M_OFF;
                  elapsed_r <= 18'd0; last_cmd_r <= 5'd0;
                end else blink_r <= el_inc[8];
              end else if (mode_r != M_OFF && el_inc >= {2'b0, step_delay_r}) begin
                if (mode_r == M_NEUTRAL) begin
                  alloff_r <= 1'b1; mode_r <= M_OFF; elapsed_r <= 18'd0;
                  last_cmd_r <= 5'd0;
                end else begin
                  cls_r <= gait_tab(pattern_r, nph); mode_r <= M_REP0 + {1'b0, nph};
                  elapsed_r <= 18'd0;
                end
              end
            end
            OP_WALK: if (com_r != last_cmd_r) begin
              last_cmd_r <= com_r;
              if (com_r == 5'd0) begin
                if (mode_r != M_NEUTRAL && mode_r != M_OFF) begin
                  cls_r <= mk(1,1,1,1,1,1,1,1); mode_r <= M_NEUTRAL; elapsed_r <= 18'd0;
                end
              end else if (com_r <= 5'd15) begin
                pattern_r <= com_r[3:0];
                cls_r <= gait_tab(com_r[3:0], 2'd0);
                mode_r <= (com_r >= 5'd7 && com_r <= 5'd12) ? M_NORMAL : M_REP0;
                elapsed_r <= 18'd0;
              end
            end
            OP_POSE: begin
              for (int i = 0; i < SERVO_COUNT; i++)
                cls_r[i] <= (lvl_r[i] <= 3'd4) ? lvl_r[i] : 3'd0;
              mode_r <= M_POSE; elapsed_r <= 18'd0; last_cmd_r <= POSE_CODE;
            end
            OP_LEG: if (!leg_r[2]) begin
              cls_r[{leg_r[1:0], 1'b0}] <= (lvl_r[0] <= 3'd4) ? lvl_r[0] : 3'd0;
              cls_r[{leg_r[1:0], 1'b1}] <= (lvl_r[1] <= 3'd4) ? lvl_r[1] : 3'd0;
              mode_r <= M_POSE; elapsed_r <= 18'd0; last_cmd_r <= POSE_CODE;
            end
            OP_INIT: begin
              cls_r <= mk(1,1,1,1,1,1,1,1); mode_r <= M_NEUTRAL; elapsed_r <= 18'd0;
            end
            default: ;
          endcase
        end
        S_RUN: if (out_free) begin
          if (cur_wr) begin
            owv_r <= 1'b1;
            och_r <= alloff_r ? slot_r : chan_of(slot_r);
            opl_r <= alloff_r ? 9'd0 : cur_pulse;
            oled_r <= blink_r; oson_r <= (mode_r != M_OFF);
            olast_r <= !more_wr; any_r <= 1'b1;
          end
          slot_r <= slot_r + 3'd1;
          if (slot_r == 3'(SERVO_COUNT - 1)) state_r <= S_FIN;
        end
        S_FIN: if (!any_r) begin
          if (out_free) begin
            owv_r <= 1'b0; och_r <= 3'd0; opl_r <= 9'd0; olast_r <= 1'b1;
            oled_r <= blink_r; oson_r <= (mode_r != M_OFF);
            state_r <= S_IDLE;
          end
        end else begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SGS_ASSERT(a_stall_busy, state_r != S_IDLE, in_stall)
  `SGS_ASSERT(a_off_pulse, ov_r && owv_r && opl_r != 9'd0, opl_r >= 9'd200 && opl_r <= 9'd400)
  `SGS_ASSERT(a_none_last, ov_r && !owv_r, olast_r)
  `SGS_ASSERT_NEXT(a_take, in_valid && !in_stall, state_r == S_DEC)
  `SGS_ASSERT_NEXT(a_hold, ov_r && out_stall, ov_r && $stable(opl_r) && $stable(olast_r))
endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the servo gait sequencer with a built-in state predictor.
module tb_top;
  import sgs_pkg::*;

  localparam logic [4:0] CMD_STOP = 5'd0;
  localparam logic [4:0] CMD_FW = 5'd1;
  localparam logic [4:0] CMD_ALL_BOB = 5'd15;
  localparam logic [4:0] CMD_IGNORED = 5'd16;
  localparam logic [4:0] CMD_TOP = 5'd31;
  localparam logic [2:0] OP_TOP = 3'd7;
  localparam logic [17:0] COUNT_CAP = 18'd262143;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] com;
    logic [2:0] leg;
    logic [7:0][2:0] lv;
  } gait_item_t;

  typedef struct packed {
    logic wv;
    logic [2:0] ch;
    logic [8:0] pulse;
    logic led;
    logic son;
    logic last;
  } servo_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [4:0] in_command = '0;
  logic [2:0] in_leg_index = '0;
  logic [2:0] in_level_0 = '0, in_level_1 = '0, in_level_2 = '0, in_level_3 = '0;
  logic [2:0] in_level_4 = '0, in_level_5 = '0, in_level_6 = '0, in_level_7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_write_valid;
  logic [2:0] out_channel;
  logic [8:0] out_pulse;
  logic out_led_on, out_servo_on, out_last;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  servo_gait_sequencer dut (.*);

  always #6 clk = ~clk;

  int deg_table [5][8] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{70, 85, 68, 90, 90, 90, 90, 90},
    '{58, 60, 55, 80, 105, 110, 103, 90},
    '{80, 90, 75, 110, 80, 80, 80, 60},
    '{130, 85, 130, 90, 20, 90, 20, 90}};
  int slot_channel [8] = '{1, 0, 5, 4, 3, 2, 7, 6};
  logic [31:0] gait_words [16][4] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0},
    '{32'h03020203, 32'h30202030, 32'h02030302, 32'h20303020},
    '{32'h03020203, 32'h20303020, 32'h02030302, 32'h30202030},
    '{32'h03020302, 32'h20303020, 32'h02030203, 32'h30202030},
    '{32'h03020302, 32'h30202030, 32'h02030203, 32'h20303020},
    '{32'h03030303, 32'h20303020, 32'h02020202, 32'h30202030},
    '{32'h03030303, 32'h30202030, 32'h02020202, 32'h20303020},
    '{32'h20202020, 32'h0, 32'h0, 32'h0},
    '{32'h40404040, 32'h0, 32'h0, 32'h0},
    '{32'h20402040, 32'h0, 32'h0, 32'h0},
    '{32'h40204020, 32'h0, 32'h0, 32'h0},
    '{32'h20204040, 32'h0, 32'h0, 32'h0},
    '{32'h40402020, 32'h0, 32'h0, 32'h0},
    '{32'h20202020, 32'h20402040, 32'h20202020, 32'h20402040},
    '{32'h40402020, 32'h20204040, 32'h40402020, 32'h20204040},
    '{32'h20202020, 32'h40404040, 32'h20202020, 32'h40404040}};

  logic [15:0] step_delay_q;
  logic [2:0] mode_q;
  logic [3:0] pattern_q;
  logic [17:0] elapsed_q;
  logic [4:0] last_cmd_q;
  logic blink_q;

  servo_write_t expected_writes[$];
  servo_write_t item_writes[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  function automatic void move_slots(input logic [7:0][2:0] cls, input logic [2:0] next_mode);
    servo_write_t w;
    int deg, p;
    for (int i = 0; i < 8; i++) begin
      if (cls[i] >= 1 && cls[i] <= 4) begin
        deg = deg_table[cls[i]][i];
        p = (deg >= 20) ? (deg - 20) * 200 / 110 + 200 : 0;
        if (p >= 200 && p <= 400 && item_writes.size() < 8) begin
          w = '0;
          w.wv = 1'b1;
          w.ch = 3'(slot_channel[i]);
          w.pulse = 9'(p);
          item_writes.push_back(w);
        end
      end
    end
    mode_q = next_mode;
    elapsed_q = '0;
  endfunction

  function automatic void switch_all_off();
    servo_write_t w;
    for (int i = 0; i < 8; i++) begin
      w = '0;
      w.wv = 1'b1;
      w.ch = 3'(i);
      item_writes.push_back(w);
    end
    mode_q = M_OFF;
    elapsed_q = '0;
    last_cmd_q = CMD_STOP;
  endfunction

  function automatic logic [7:0][2:0] gait_classes(input logic [3:0] pat, input int ph);
    logic [7:0][2:0] c;
    for (int i = 0; i < 8; i++) c[i] = 3'((gait_words[pat][ph] >> (28 - 4 * i)) & 32'hf);
    return c;
  endfunction

  function automatic void predict_servo_writes(input gait_item_t it);
    logic [7:0][2:0] cls, one;
    servo_write_t w;
    int nxt;
    item_writes.delete();
    for (int i = 0; i < 8; i++) cls[i] = (it.lv[i] <= 4) ? it.lv[i] : 3'd0;
    case (it.op)
      OP_TICK: begin
        if (elapsed_q < COUNT_CAP) elapsed_q++;
        if (mode_q == M_POSE || mode_q == M_NORMAL) begin
          if (elapsed_q >= HOLD_TIMEOUT_MS) begin
            switch_all_off();
            blink_q = 1'b0;
          end else begin
            blink_q = elapsed_q[8];
          end
        end else if (mode_q != M_OFF && elapsed_q >= 18'(step_delay_q)) begin
          if (mode_q == M_NEUTRAL) begin
            switch_all_off();
          end else begin
            nxt = (int'(mode_q - M_REP0) + 1) % 4;
            move_slots(gait_classes(pattern_q, nxt), 3'(M_REP0 + nxt));
          end
        end
      end
      OP_WALK: begin
        if (it.com != last_cmd_q) begin
          last_cmd_q = it.com;
          if (it.com == CMD_STOP) begin
            if (mode_q != M_NEUTRAL && mode_q != M_OFF) move_slots('{default: 3'd1}, M_NEUTRAL);
          end else if (it.com <= CMD_ALL_BOB) begin
            pattern_q = it.com[3:0];
            move_slots(gait_classes(it.com[3:0], 0),
                       (it.com >= 7 && it.com <= 12) ? M_NORMAL : M_REP0);
          end
        end
      end
      OP_POSE: begin
        move_slots(cls, M_POSE);
        last_cmd_q = POSE_CODE;
      end
      OP_LEG: begin
        if (it.leg < 4) begin
          one = '0;
          one[it.leg * 2] = cls[0];
          one[it.leg * 2 + 1] = cls[1];
          move_slots(one, M_POSE);
          last_cmd_q = POSE_CODE;
        end
      end
      OP_INIT: move_slots('{default: 3'd1}, M_NEUTRAL);
      default: ;
    endcase
    if (item_writes.size() == 0) item_writes.push_back('0);
    foreach (item_writes[i]) begin
      w = item_writes[i];
      w.led = blink_q;
      w.son = (mode_q != M_OFF);
      w.last = (i == item_writes.size() - 1);
      expected_writes.push_back(w);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input gait_item_t it);
    int g;
    in_valid <= 1'b1;
    in_opcode <= it.op;
    in_command <= it.com;
    in_leg_index <= it.leg;
    in_level_0 <= it.lv[0];
    in_level_1 <= it.lv[1];
    in_level_2 <= it.lv[2];
    in_level_3 <= it.lv[3];
    in_level_4 <= it.lv[4];
    in_level_5 <= it.lv[5];
    in_level_6 <= it.lv[6];
    in_level_7 <= it.lv[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_servo_writes(it);
    g = idle_on ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [2:0] op, input logic [4:0] com = '0,
                         input logic [2:0] leg = '0, input logic [7:0][2:0] lv = '0);
    gait_item_t it;
    it.op = op;
    it.com = com;
    it.leg = leg;
    it.lv = lv;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step_delay(input logic [15:0] value);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(ADDR_STEP_DELAY << 2);
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    step_delay_q = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [2:0] rand_level();
    return ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
  endfunction

  function automatic gait_item_t rand_item();
    gait_item_t it;
    int r;
    it.com = 5'($urandom_range(0, 9) < 8 ? $urandom_range(0, 15) : $urandom_range(16, 31));
    it.leg = 3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(4, 7));
    for (int i = 0; i < 8; i++) it.lv[i] = rand_level();
    r = $urandom_range(0, 99);
    if (r < 50) it.op = OP_TICK;
    else if (r < 72) it.op = OP_WALK;
    else if (r < 82) it.op = OP_POSE;
    else if (r < 90) it.op = OP_LEG;
    else if (r < 95) it.op = OP_INIT;
    else it.op = 3'($urandom_range(5, 7));
    return it;
  endfunction

  task automatic test_walk_codes();
    send_op(OP_INIT);
    send_op(OP_WALK, CMD_FW);
    send_op(OP_WALK, CMD_FW);
    repeat (4) send_op(OP_TICK);
    for (int c = 2; c <= CMD_ALL_BOB; c++) send_op(OP_WALK, 5'(c));
    send_op(OP_WALK, CMD_IGNORED);
    send_op(OP_WALK, CMD_TOP);
    send_op(OP_WALK, CMD_STOP);
    send_op(OP_WALK, CMD_STOP);
    send_op(OP_WALK, CMD_FW);
  endtask

  task automatic test_pose_requests();
    logic [7:0][2:0] lv;
    send_op(OP_POSE, CMD_TOP, OP_TOP, '{default: 3'd4});
    send_op(OP_POSE, '0, '0, '{default: 3'd7});
    send_op(OP_POSE, '0, '0, '{3'd3, 3'd2, 3'd1, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7});
    for (int l = 0; l < 8; l++) begin
      lv = '{3'd7, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd2};
      lv[0] = lv[0] ^ 3'(l);
      lv[1] = lv[1] ^ 3'(l);
      send_op(OP_LEG, '0, 3'(l), lv);
    end
    for (int k = 1; k <= 3; k++) send_op(OP_INIT + 3'(k), CMD_TOP, OP_TOP, '{default: 3'd7});
    send_op(OP_WALK, CMD_STOP);
  endtask

  task automatic test_step_delay_extremes();
    write_step_delay(16'd0);
    send_op(OP_INIT);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_op(OP_WALK, 5'd13);
    repeat (6) send_op(OP_TICK);
    write_step_delay(16'hffff);
    send_op(OP_WALK, 5'd14);
    repeat (5) send_op(OP_TICK);
    send_op(OP_INIT);
    repeat (3) send_op(OP_TICK);
  endtask

  task automatic test_random_traffic(input int count);
    gait_item_t it;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n % 90 == 45) write_step_delay(16'($urandom_range(0, 6)));
      if ($urandom_range(0, 9) < 3) begin
        it = rand_item();
        it.op = ($urandom_range(0, 1) != 0) ? OP_WALK : OP_INIT;
        send_item(it);
        repeat ($urandom_range(2, 8)) send_op(OP_TICK);
        n += 4;
      end else begin
        send_item(rand_item());
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_holdoff();
    send_op(OP_INIT);
    hold_req = 1'b1;
    for (int n = 0; n < 20; n++) send_op(OP_WALK, 5'(n % 2 ? 8 : 15));
    wait_drained();
    repeat (10) send_op(OP_TICK);
  endtask

  always @(posedge clk) begin
    int left;
    logic s;
    s = 1'b0;
    if (hold_req) begin
      hold_req = 1'b0;
      left = 400;
    end
    if (left > 0) begin
      left--;
      s = 1'b1;
    end else if (stall_on && $urandom_range(0, 9) < 3) begin
      left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      s = 1'b1;
    end
    out_stall <= s;
  end

  always @(posedge clk) begin
    servo_write_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_write_valid, out_channel, out_pulse, out_led_on, out_servo_on, out_last};
      if (expected_writes.size() == 0) begin
        $display("%0t unexpected transfer: got %p", $time, got);
        errors++;
      end else begin
        want = expected_writes.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    step_delay_q = 16'd200;
    mode_q = M_OFF;
    pattern_q = '0;
    elapsed_q = '0;
    last_cmd_q = CMD_STOP;
    blink_q = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_step_delay(16'd2);
    test_walk_codes();
    test_pose_requests();
    test_step_delay_extremes();
    write_step_delay(16'd3);
    test_random_traffic(200);
    test_output_holdoff();
    write_step_delay(16'd200);
    test_random_traffic(170);
    wait_drained();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
